### hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Shared widths, command and result codes, unit opcodes and word types.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int TIME_W   = 48;
   localparam int PERIOD_W = 32;
   localparam int SLOT_W   = 4;
   localparam int CMD_W    = 2;
   localparam int KIND_W   = 2;

   // Up to this many fired words come out of one tick.
   localparam int FIRE_CNT_W = 5;
   localparam logic [FIRE_CNT_W-1:0] MAX_FIRE = 5'd16;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADD_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK_NONE = 2'd3;

   // Opcodes of the shared arithmetic unit.
   localparam logic OP_GE  = 1'b0;
   localparam logic OP_ADD = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic              ok;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic exp_en;
      logic per_en;
   } store_wr_type;

endpackage

### hdl/stt_if.sv
// ----------------------------------------------------------------------------
// Timer table channels
// Valid/ready interfaces for the command channel and the result channel.
// ----------------------------------------------------------------------------
interface stt_req_if;
   logic                          valid;
   logic                          ready;
   logic [stt_pkg::CMD_W-1:0]     command;
   logic [stt_pkg::SLOT_W-1:0]    slot;
   logic [stt_pkg::TIME_W-1:0]    expiry_us;
   logic [stt_pkg::PERIOD_W-1:0]  reload_us;
   logic                          start_active;
   logic [stt_pkg::TIME_W-1:0]    now_us;

   modport source (output valid, command, slot, expiry_us, reload_us, start_active,
                   now_us, input ready);
   modport sink (input valid, command, slot, expiry_us, reload_us, start_active,
                 now_us, output ready);
endinterface

interface stt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [stt_pkg::KIND_W-1:0]  kind;
   logic [stt_pkg::SLOT_W-1:0]  fired_slot;
   logic                        ok;
   logic                        last;

   modport source (output valid, kind, fired_slot, ok, last, input ready);
   modport sink (input valid, kind, fired_slot, ok, last, output ready);
endinterface

### hdl/stt_alu.sv
// ----------------------------------------------------------------------------
// Timer table arithmetic unit
// One shared 48-bit saturating adder and magnitude compare.
// ----------------------------------------------------------------------------
module stt_alu (
   input  logic                        op,
   input  logic [stt_pkg::TIME_W-1:0]  a,
   input  logic [stt_pkg::TIME_W-1:0]  b,
   output logic [stt_pkg::TIME_W-1:0]  res
);

   logic [stt_pkg::TIME_W:0] sum;

   assign sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (op)
         stt_pkg::OP_ADD: begin
            // A carry out means the time passed the top of the range; clamp it.
            res = sum[stt_pkg::TIME_W] ? '1 : sum[stt_pkg::TIME_W-1:0];
         end
         stt_pkg::OP_GE: begin
            res = {{(stt_pkg::TIME_W-1){1'b0}}, (a >= b)};
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

### hdl/stt_store.sv
// ----------------------------------------------------------------------------
// Timer table slot store
// Expiry and period memories with one write port and a registered read.
// ----------------------------------------------------------------------------
module stt_store #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  logic                          clock,
   input  stt_pkg::store_wr_type         wr,
   input  logic [IW-1:0]                 wr_addr,
   input  logic [stt_pkg::TIME_W-1:0]    wr_exp,
   input  logic [stt_pkg::PERIOD_W-1:0]  wr_per,
   input  logic [IW-1:0]                 rd_addr,
   output logic [stt_pkg::TIME_W-1:0]    rd_exp_ff,
   output logic [stt_pkg::PERIOD_W-1:0]  rd_per_ff
);

   logic [stt_pkg::TIME_W-1:0]   expiry_mem_ff [DEPTH];
   logic [stt_pkg::PERIOD_W-1:0] period_mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.exp_en) begin
         expiry_mem_ff[wr_addr] <= wr_exp;
      end
      rd_exp_ff <= expiry_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.per_en) begin
         period_mem_ff[wr_addr] <= wr_per;
      end
      rd_per_ff <= period_mem_ff[rd_addr];
   end

endmodule

### hdl/software_timer_table_core.sv
// Add and remove: the result word is registered in the response state, and ready
// returns with it. Tick: each slot is read (READ) and compared (CMP); a due periodic
// slot also passes ADD1 and CHK, plus ADD2 when its advanced expiry is still in the
// past, and DONE closes the scan; one compare/add unit and one memory read port set this.
// Reset clears the present and active marks; expiry and period memories hold
// nothing meaningful until a slot is added.
// ----------------------------------------------------------------------------
// Timer table core
// Slot table with add, remove and a tick scan that reports fired timers.
// ----------------------------------------------------------------------------
module software_timer_table_core #(
   parameter int SLOTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req,
   stt_rsp_if.source rsp
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
   localparam logic [8:0] SLOTS_LIM = 9'(SLOTS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RESP = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_ADD1 = 3'd4;
   localparam logic [2:0] ST_CHK  = 3'd5;
   localparam logic [2:0] ST_ADD2 = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   logic [2:0]                        state_ff, state_in;
   logic [IW-1:0]                     idx_ff, idx_in;
   logic [stt_pkg::FIRE_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [stt_pkg::TIME_W-1:0]        now_ff, now_in;
   logic [stt_pkg::TIME_W-1:0]        sum_ff, sum_in;
   logic [SLOTS-1:0]                  present_ff, present_in;
   logic [SLOTS-1:0]                  active_ff, active_in;
   logic                              pend_valid_ff, pend_valid_in;
   stt_pkg::rsp_word_type             pend_word_ff, pend_word_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   stt_pkg::rsp_word_type             rsp_word_ff, rsp_word_in;

   logic                              out_free;
   logic                              in_range;
   logic [IW-1:0]                     slot_idx;
   logic                              due;
   logic                              scan_end;

   logic                              alu_op;
   logic [stt_pkg::TIME_W-1:0]        alu_a, alu_b, alu_res;

   stt_pkg::store_wr_type             wr;
   logic [IW-1:0]                     wr_addr;
   logic [stt_pkg::TIME_W-1:0]        wr_exp;
   logic [stt_pkg::TIME_W-1:0]        rd_exp;
   logic [stt_pkg::PERIOD_W-1:0]      rd_per;

   stt_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   stt_store #(
      .DEPTH (SLOTS),
      .IW    (IW)
   ) u_store (
      .clock     (clock),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .wr_exp    (wr_exp),
      .wr_per    (req.reload_us),
      .rd_addr   (idx_ff),
      .rd_exp_ff (rd_exp),
      .rd_per_ff (rd_per)
   );

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_word_ff.kind;
   assign rsp.fired_slot = rsp_word_ff.slot;
   assign rsp.ok         = rsp_word_ff.ok;
   assign rsp.last       = rsp_word_ff.last;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign in_range = ({5'd0, req.slot} < SLOTS_LIM);
   assign slot_idx = IW'(req.slot);
   assign scan_end = (idx_ff == LAST_IDX);
   assign due      = present_ff[idx_ff] && active_ff[idx_ff] && alu_res[0];

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      sum_in        = sum_ff;
      present_in    = present_ff;
      active_in     = active_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_word_in   = rsp_word_ff;
      alu_op        = stt_pkg::OP_GE;
      alu_a         = now_ff;
      alu_b         = rd_exp;
      wr            = '0;
      wr_addr       = idx_ff;
      wr_exp        = alu_res;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               case (req.command)
                  stt_pkg::CMD_ADD: begin
                     pend_word_in  = '{stt_pkg::KIND_ADD_ACK, req.slot, in_range, 1'b1};
                     pend_valid_in = 1'b1;
                     state_in      = ST_RESP;
                     if (in_range) begin
                        wr                   = '{exp_en: 1'b1, per_en: 1'b1};
                        wr_addr              = slot_idx;
                        wr_exp               = req.expiry_us;
                        present_in[slot_idx] = 1'b1;
                        active_in[slot_idx]  = req.start_active;
                     end
                  end
                  stt_pkg::CMD_REMOVE: begin
                     pend_word_in  = '{stt_pkg::KIND_REMOVE, req.slot,
                                       in_range && present_ff[slot_idx], 1'b1};
                     pend_valid_in = 1'b1;
                     state_in      = ST_RESP;
                     if (in_range) begin
                        present_in[slot_idx] = 1'b0;
                     end
                  end
                  stt_pkg::CMD_TICK: begin
                     now_in        = req.now_us;
                     idx_in        = '0;
                     cnt_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = pend_word_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!due) begin
               idx_in   = idx_ff + 1'b1;
               state_in = scan_end ? ST_DONE : ST_READ;
            end else if (!pend_valid_ff || out_free) begin
               // The previous fired word is not the last one; send it on.
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = pend_word_ff;
               end
               pend_word_in  = '{stt_pkg::KIND_FIRED, 4'(idx_ff), 1'b0, 1'b0};
               pend_valid_in = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
               if (rd_per == '0) begin
                  active_in[idx_ff] = 1'b0;
                  idx_in            = idx_ff + 1'b1;
                  state_in = (scan_end || cnt_in == stt_pkg::MAX_FIRE) ? ST_DONE : ST_READ;
               end else begin
                  state_in = ST_ADD1;
               end
            end
         end
         ST_ADD1: begin
            alu_op   = stt_pkg::OP_ADD;
            alu_a    = rd_exp;
            alu_b    = {16'd0, rd_per};
            sum_in   = alu_res;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            alu_a = sum_ff;
            alu_b = now_ff;
            if (alu_res[0]) begin
               wr.exp_en = 1'b1;
               wr_exp    = sum_ff;
               idx_in    = idx_ff + 1'b1;
               state_in  = (scan_end || cnt_ff == stt_pkg::MAX_FIRE) ? ST_DONE : ST_READ;
            end else begin
               state_in = ST_ADD2;
            end
         end
         ST_ADD2: begin
            alu_op    = stt_pkg::OP_ADD;
            alu_a     = now_ff;
            alu_b     = {16'd0, rd_per};
            wr.exp_en = 1'b1;
            idx_in    = idx_ff + 1'b1;
            state_in  = (scan_end || cnt_ff == stt_pkg::MAX_FIRE) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_word_in      = pend_word_ff;
                  rsp_word_in.last = 1'b1;
               end else begin
                  rsp_word_in = '{stt_pkg::KIND_TICK_NONE, 4'd0, 1'b0, 1'b1};
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         present_ff    <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         present_ff    <= present_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      sum_ff       <= sum_in;
      pend_word_ff <= pend_word_in;
      rsp_word_ff  <= rsp_word_in;
   end

endmodule
